// ----- rtl/agx_pkg.sv -----
`timescale 1ns / 1ps
package agx_pkg;

  localparam logic signed [20:0] EvMin = -21'sd817491;
  localparam logic signed [20:0] EvMax = 21'sd263852;
  localparam logic [20:0] EvSpan = 21'd1081343;
  localparam logic signed [17:0] CubeC3 = -18'sd4280;
  localparam logic signed [17:0] CubeC2 = 18'sd82104;
  localparam logic signed [17:0] CubeC1 = -18'sd12222;
  localparam logic [16:0] LumaWr = 17'd13933;
  localparam logic [16:0] LumaWg = 17'd46871;
  localparam logic [16:0] LumaWb = 17'd4732;
  localparam logic [17:0] SatGain = 18'd78643;
  localparam logic [17:0] ConGain = 18'd75366;
  localparam logic [16:0] MidGray = 17'd11796;

  localparam logic [0:0] AddrLookMode = 1'b0;

  function automatic logic [16:0] log_tab(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0: v = 17'd0;
      5'd1: v = 17'd5732;
      5'd2: v = 17'd11136;
      5'd3: v = 17'd16248;
      5'd4: v = 17'd21098;
      5'd5: v = 17'd25711;
      5'd6: v = 17'd30109;
      5'd7: v = 17'd34312;
      5'd8: v = 17'd38336;
      5'd9: v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic [16:0] r;
    logic [16:0] g;
    logic [16:0] b;
  } rgb_t;

endpackage

// ----- rtl/agx_curve.sv -----
`timescale 1ns / 1ps
// One channel: log2, normalize, cubic. Seven register stages.
module agx_curve
  import agx_pkg::*;
(
  input  logic        clk_i,
  input  logic [31:0] x_i,
  output logic [16:0] y_o
);

  // stage 1: leading one, table lookup
  logic [4:0]  p_d;
  logic [29:0] f30_d;
  logic        zero_d;
  logic [4:0]  p_q;
  logic [16:0] t0_q, dt_q;
  logic [15:0] r_q;
  logic        zero_q;

  always_comb begin
    p_d = 5'd0;
    for (int i = 0; i <= 30; i++) begin
      if (x_i[i]) p_d = 5'(i);
    end
    f30_d = 30'(x_i[30:0] << (5'd30 - p_d));
    zero_d = (x_i == 32'd0) || x_i[31];
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    t0_q   <= log_tab({1'b0, f30_d[29:26]});
    dt_q   <= log_tab({1'b0, f30_d[29:26]} + 5'd1) - log_tab({1'b0, f30_d[29:26]});
    r_q    <= f30_d[25:10];
    zero_q <= zero_d;
  end

  // stage 2: log value and distance from EvMin
  logic [32:0] prod2;
  logic signed [21:0] lg;
  logic [20:0] dist_q;
  logic        lo_q, hi_q, zero2_q;
  assign prod2 = dt_q * r_q;
  assign lg = 22'sd65536 * ($signed({1'b0, p_q}) - 22'sd24)
            + $signed({5'd0, t0_q}) + $signed({5'd0, prod2[32:16]});
  always_ff @(posedge clk_i) begin
    dist_q  <= 21'(lg - 22'(EvMin));
    lo_q    <= lg <= 22'(EvMin);
    hi_q    <= lg >= 22'(EvMax);
    zero2_q <= zero_q;
  end

  // stage 3: t = round(d*65536/span) by reciprocal
  // q = (d*K + 2^25) >> 26 with K = ceil(2^42/span) is exact or one high
  localparam logic [21:0] RecipK = 22'((64'd1 << 42) / 64'(EvSpan) + 64'd1);
  logic [37:0] num;
  logic [42:0] qprod;
  logic [16:0] qest_q;
  logic [37:0] num_q;
  logic        lo3_q, hi3_q, z3_q;
  assign num   = {1'b0, dist_q, 16'd0} + 38'd540671;
  assign qprod = dist_q * RecipK + 43'd33554432;
  always_ff @(posedge clk_i) begin
    qest_q <= qprod[42:26];
    num_q  <= num;
    lo3_q  <= lo_q;
    hi3_q  <= hi_q;
    z3_q   <= zero2_q;
  end

  // stage 4: one correction step and the clamps
  logic [16:0] t_d, t_q;
  logic [37:0] chk;
  logic        z4_q;
  always_comb begin
    chk = qest_q * EvSpan;
    t_d = qest_q;
    if (chk > num_q) t_d = qest_q - 17'd1;
    if (lo3_q) t_d = 17'd0;
    else if (hi3_q || t_d > 17'd65536) t_d = 17'd65536;
  end
  always_ff @(posedge clk_i) begin
    t_q  <= t_d;
    z4_q <= z3_q;
  end

  // stage 5: t2
  logic [16:0] t5_q, t2_q;
  logic        z5_q;
  logic [33:0] sq;
  assign sq = t_q * t_q + 34'd32768;
  always_ff @(posedge clk_i) begin
    t5_q <= t_q;
    t2_q <= 17'(sq[33:16]);
    z5_q <= z4_q;
  end

  // stage 6: t3 and partial sums
  logic [33:0] cu;
  logic [16:0] t3;
  logic signed [37:0] s12_q;
  logic [16:0] t3_q;
  logic        z6_q;
  assign cu = t2_q * t5_q + 34'd32768;
  assign t3 = 17'(cu[33:16]);
  always_ff @(posedge clk_i) begin
    s12_q <= 38'(CubeC2 * $signed({1'b0, t2_q})) + 38'(CubeC1 * $signed({1'b0, t5_q}));
    t3_q  <= t3;
    z6_q  <= z5_q;
  end

  // stage 7: final sum
  logic signed [37:0] sum;
  logic signed [37:0] yr;
  assign sum = s12_q + 38'(CubeC3 * $signed({1'b0, t3_q}));
  assign yr = (sum + 38'sd32768) >>> 16;
  always_ff @(posedge clk_i) begin
    if (z6_q || sum <= 0) y_o <= 17'd0;
    else if (yr > 38'sd65536) y_o <= 17'd65536;
    else y_o <= 17'(yr);
  end

endmodule

// ----- rtl/agx_grade.sv -----
`timescale 1ns / 1ps
// Punchy grade: luma, saturation, contrast. Three register stages.
module agx_grade
  import agx_pkg::*;
(
  input  logic  clk_i,
  input  logic  punchy_i,
  input  rgb_t  c_i,
  output rgb_t  c_o
);

  function automatic logic signed [23:0] rnd(input logic signed [40:0] a);
    logic signed [40:0] m;
    m = a >= 0 ? a : -a;
    m = (m + 41'sd32768) >>> 16;
    return 24'(a >= 0 ? m : -m);
  endfunction

  logic [34:0] lsum;
  logic [16:0] luma_q;
  rgb_t c1_q;
  logic p1_q;
  assign lsum = c_i.r * LumaWr + c_i.g * LumaWg + c_i.b * LumaWb + 35'd32768;
  always_ff @(posedge clk_i) begin
    luma_q <= 17'(lsum[34:16]);
    c1_q   <= c_i;
    p1_q   <= punchy_i;
  end

  logic signed [23:0] s_d [3], s_q [3];
  logic [16:0] cin [3];
  rgb_t c2_q;
  logic p2_q;
  assign cin[0] = c1_q.r;
  assign cin[1] = c1_q.g;
  assign cin[2] = c1_q.b;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_d[i] = 24'($signed({1'b0, luma_q}))
             + rnd(41'($signed({1'b0, cin[i]}) - $signed({1'b0, luma_q}))
                   * $signed({1'b0, SatGain}));
    end
  end
  always_ff @(posedge clk_i) begin
    s_q  <= s_d;
    c2_q <= c1_q;
    p2_q <= p1_q;
  end

  logic signed [23:0] y [3];
  logic [16:0] yo [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y[i] = 24'($signed({1'b0, MidGray}))
           + rnd(41'(s_q[i] - $signed({1'b0, MidGray})) * $signed({1'b0, ConGain}));
      if (y[i] < 0) yo[i] = 17'd0;
      else if (y[i] > 24'sd65536) yo[i] = 17'd65536;
      else yo[i] = 17'(y[i]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (p2_q) c_o <= '{r: yo[0], g: yo[1], b: yo[2]};
    else c_o <= c2_q;
  end

endmodule

// ----- rtl/agx_log_tone_map_rgb_unit.sv -----
`timescale 1ns / 1ps
// Log tone map, linear RGB (signed Q8.24) to display RGB (Q1.16, 0..65536).
// Request channel: raise start_i with the pixel on red_i, green_i, blue_i and
// end_of_batch_i; it is taken at a clock edge where busy_o is low. busy_o is
// always low, so one pixel is taken every cycle.
// Result channel: done_o is high for exactly one cycle with red_o, green_o,
// blue_o and batch_done_o; the receiver cannot stall it.
// The pipeline has ten register stages: seven for the per-channel log, divide
// and cubic curve, three for the grade (luma, saturation, contrast). done_o
// comes from a valid shift register of the same depth, so it rises together
// with red_o, green_o, blue_o. Throughput is one pixel per clock, since every
// stage is fully pipelined. Results keep request order.
// look_mode is written over the APB port at address 0 (bit 0) and should
// change only while no pixel is in flight; it is sampled per pixel at the
// grade stage.
// Reset clears look_mode and all valid bits; pixels in flight are dropped.
module agx_log_tone_map_rgb_unit
  import agx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] red_i,
  input  logic [31:0] green_i,
  input  logic [31:0] blue_i,
  input  logic        end_of_batch_i,
  output logic        done_o,
  output logic [16:0] red_o,
  output logic [16:0] green_o,
  output logic [16:0] blue_o,
  output logic        batch_done_o
);

  localparam int unsigned Lat = 10;

  logic look_q;
  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign prdata = (paddr == AddrLookMode) ? {31'd0, look_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) look_q <= 1'b0;
    else if (psel && penable && pwrite && paddr == AddrLookMode) look_q <= pwdata[0];
  end

  logic [16:0] curve_r, curve_g, curve_b;
  rgb_t curve, graded;
  agx_curve u_r (.clk_i, .x_i(red_i),   .y_o(curve_r));
  agx_curve u_g (.clk_i, .x_i(green_i), .y_o(curve_g));
  agx_curve u_b (.clk_i, .x_i(blue_i),  .y_o(curve_b));
  assign curve = '{r: curve_r, g: curve_g, b: curve_b};
  agx_grade u_grade (.clk_i, .punchy_i(look_q), .c_i(curve), .c_o(graded));

  logic [Lat-1:0] vld_q, eob_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start_i};
    end
  end
  always_ff @(posedge clk_i) begin
    eob_q <= {eob_q[Lat-2:0], end_of_batch_i};
  end

  assign done_o       = vld_q[Lat-1];
  assign batch_done_o = eob_q[Lat-1];
  assign red_o        = graded.r;
  assign green_o      = graded.g;
  assign blue_o       = graded.b;

endmodule
